### rtl/core/ntpl_pkg.sv
// Shared types and constants for the nearest timestamp pose lookup.
// No dependencies; ntpl_if, ntpl_alu and the top level import this package.
package ntpl_pkg;

    localparam int STAMP_W  = 63;
    localparam int FIELD_W  = 32;
    localparam int STATUS_W = 2;
    localparam int NUM_POSE = 7;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_DECIDE,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_PUT,
        ST_DIST_LO,
        ST_DIST_HI,
        ST_PICK,
        ST_FETCH_RD,
        ST_EMIT
    } t_state;

    // Result of the shared subtract/compare unit.
    typedef struct packed {
        logic [STAMP_W-1:0] diff;
        logic               lt;
        logic               eq;
    } t_cmp;

endpackage

### rtl/core/ntpl_if.sv
// Valid/ready channel interfaces for the command and result streams.
// Depends on ntpl_pkg.
interface ntpl_cmd_if import ntpl_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      command;
    logic [STAMP_W-1:0]        stamp;
    logic signed [FIELD_W-1:0] pos_x_in;
    logic signed [FIELD_W-1:0] pos_y_in;
    logic signed [FIELD_W-1:0] pos_z_in;
    logic signed [FIELD_W-1:0] rot_x_in;
    logic signed [FIELD_W-1:0] rot_y_in;
    logic signed [FIELD_W-1:0] rot_z_in;
    logic signed [FIELD_W-1:0] rot_w_in;

    modport source (
        output valid, command, stamp, pos_x_in, pos_y_in, pos_z_in,
               rot_x_in, rot_y_in, rot_z_in, rot_w_in,
        input  ready
    );
    modport sink (
        input  valid, command, stamp, pos_x_in, pos_y_in, pos_z_in,
               rot_x_in, rot_y_in, rot_z_in, rot_w_in,
        output ready
    );
endinterface

interface ntpl_res_if import ntpl_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [STATUS_W-1:0]       status;
    logic [STAMP_W-1:0]        chosen_stamp;
    logic signed [FIELD_W-1:0] pos_x_out;
    logic signed [FIELD_W-1:0] pos_y_out;
    logic signed [FIELD_W-1:0] pos_z_out;
    logic signed [FIELD_W-1:0] rot_x_out;
    logic signed [FIELD_W-1:0] rot_y_out;
    logic signed [FIELD_W-1:0] rot_z_out;
    logic signed [FIELD_W-1:0] rot_w_out;

    modport source (
        output valid, status, chosen_stamp, pos_x_out, pos_y_out, pos_z_out,
               rot_x_out, rot_y_out, rot_z_out, rot_w_out,
        input  ready
    );
    modport sink (
        input  valid, status, chosen_stamp, pos_x_out, pos_y_out, pos_z_out,
               rot_x_out, rot_y_out, rot_z_out, rot_w_out,
        output ready
    );
endinterface

### rtl/core/nearest_timestamp_pose_lookup.sv
// Top level: sorted pose table with insert and nearest-timestamp query.
// Depends on ntpl_pkg, ntpl_if (channels), ntpl_ram and ntpl_alu.
//
//  channel    | dir | handshake           | payload
//  -----------+-----+---------------------+-----------------------------------
//  i_cmd_ch   | in  | valid/ready (sink)  | command, stamp, 7 pose fields
//  o_res_ch   | out | valid/ready (source)| status, chosen_stamp, 7 pose fields
//
// One command at a time. The scan walks the table through the single RAM read
// port, with a read and a compare step per entry below the key; an insert of a
// new key then moves each later entry up with a read and a write step.
// Reset (synchronous, active low) empties the table; RAM contents are not cleared.
// A result waiting in the output register does not block accepting the next beat;
// the sequencer holds its final step until the output register is free.
module nearest_timestamp_pose_lookup import ntpl_pkg::*; #(
    parameter int TABLE_DEPTH = 64,
    parameter int POSE_BITS   = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ntpl_cmd_if.sink  i_cmd_ch,
    ntpl_res_if.source o_res_ch
);
    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int POSE_W = NUM_POSE * POSE_BITS;
    localparam int WORD_W = STAMP_W + POSE_W;

    // Control state
    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count;
    logic               r_out_valid;

    // Working registers (payload, no reset)
    logic               r_cmd;
    logic [STAMP_W-1:0] r_key;
    logic [POSE_W-1:0]  r_pose;
    logic [CNT_W-1:0]   r_idx;      // scan position, ends as insert/query position
    logic [CNT_W-1:0]   r_j;        // shift destination
    logic [STAMP_W-1:0] r_prev;     // key just below the position
    logic [STAMP_W-1:0] r_cur;      // key at the position
    logic               r_found;
    logic               r_eq;
    logic               r_new;
    logic [STAMP_W-1:0] r_below;
    logic [STAMP_W-1:0] r_above;
    logic [IDX_W-1:0]   r_sel;
    t_status            r_status;
    logic               r_hit;

    // Output register
    logic [STATUS_W-1:0] r_out_status;
    logic [STAMP_W-1:0]  r_out_stamp;
    logic [FIELD_W-1:0]  r_out_pose [NUM_POSE];

    // RAM and shared unit
    logic               ram_we, ram_re;
    logic [IDX_W-1:0]   ram_waddr, ram_raddr;
    logic [WORD_W-1:0]  ram_wdata, ram_rdata;
    logic [STAMP_W-1:0] rd_key;
    logic [STAMP_W-1:0] alu_a, alu_b;
    t_cmp               cmp;

    logic               cmd_fire;
    logic               slot_free;
    logic [CNT_W-1:0]   jm1;
    logic [CNT_W-1:0]   idx_m1;
    logic [POSE_W-1:0]  pose_in;
    logic [FIELD_W-1:0] in_field [NUM_POSE];

    assign cmd_fire  = i_cmd_ch.valid && i_cmd_ch.ready;
    assign slot_free = !r_out_valid || o_res_ch.ready;
    assign jm1       = r_j - 1'b1;
    assign idx_m1    = r_idx - 1'b1;
    assign rd_key    = ram_rdata[WORD_W-1 -: STAMP_W];

    // Hold off the input while reset is applied so no beat is taken and lost.
    assign i_cmd_ch.ready = (r_state == ST_IDLE) && i_rst_n;

    // Pose fields are kept as raw bit patterns: zero-extend or truncate to storage width.
    assign in_field[0] = i_cmd_ch.pos_x_in;
    assign in_field[1] = i_cmd_ch.pos_y_in;
    assign in_field[2] = i_cmd_ch.pos_z_in;
    assign in_field[3] = i_cmd_ch.rot_x_in;
    assign in_field[4] = i_cmd_ch.rot_y_in;
    assign in_field[5] = i_cmd_ch.rot_z_in;
    assign in_field[6] = i_cmd_ch.rot_w_in;

    always_comb begin
        for (int p = 0; p < NUM_POSE; p++) begin
            pose_in[p*POSE_BITS +: POSE_BITS] = POSE_BITS'($unsigned(in_field[p]));
        end
    end

    ntpl_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    ntpl_alu u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .o_cmp (cmp)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (cmd_fire) n_state = ST_SCAN_RD;
            end
            ST_SCAN_RD: begin
                n_state = (r_idx == r_count) ? ST_DECIDE : ST_SCAN_CMP;
            end
            ST_SCAN_CMP: begin
                n_state = cmp.lt ? ST_SCAN_RD : ST_DECIDE;
            end
            ST_DECIDE: begin
                if (r_cmd == CMD_INSERT) begin
                    if (r_found && r_eq) begin
                        n_state = ST_PUT;
                    end else if (r_count == CNT_W'(TABLE_DEPTH)) begin
                        n_state = ST_EMIT;
                    end else if (r_count != r_idx) begin
                        n_state = ST_SHIFT_RD;
                    end else begin
                        n_state = ST_PUT;
                    end
                end else begin
                    if (r_count == '0) begin
                        n_state = ST_EMIT;
                    end else if (r_idx == '0 || !r_found) begin
                        n_state = ST_FETCH_RD;
                    end else begin
                        n_state = ST_DIST_LO;
                    end
                end
            end
            ST_SHIFT_RD: n_state = ST_SHIFT_WR;
            ST_SHIFT_WR: n_state = (jm1 == r_idx) ? ST_PUT : ST_SHIFT_RD;
            ST_PUT:      n_state = ST_EMIT;
            ST_DIST_LO:  n_state = ST_DIST_HI;
            ST_DIST_HI:  n_state = ST_PICK;
            ST_PICK:     n_state = ST_FETCH_RD;
            ST_FETCH_RD: n_state = ST_EMIT;
            ST_EMIT: begin
                if (slot_free) n_state = ST_IDLE;
            end
            default:     n_state = ST_IDLE;
        endcase
    end

    // Datapath controls: RAM ports and shared unit operands
    always_comb begin
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = r_idx[IDX_W-1:0];
        ram_raddr = r_idx[IDX_W-1:0];
        ram_wdata = {r_key, r_pose};
        alu_a     = rd_key;
        alu_b     = r_key;
        unique case (r_state)
            ST_SCAN_RD: begin
                ram_re = (r_idx != r_count);
            end
            ST_SHIFT_RD: begin
                ram_re    = 1'b1;
                ram_raddr = jm1[IDX_W-1:0];
            end
            ST_SHIFT_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_j[IDX_W-1:0];
                ram_wdata = ram_rdata;
            end
            ST_PUT: begin
                ram_we = 1'b1;
            end
            ST_DIST_LO: begin
                alu_a = r_key;
                alu_b = r_prev;
            end
            ST_DIST_HI: begin
                alu_a = r_cur;
                alu_b = r_key;
            end
            ST_PICK: begin
                alu_a = r_above;
                alu_b = r_below;
            end
            ST_FETCH_RD: begin
                ram_re    = 1'b1;
                ram_raddr = r_sel;
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_PUT && r_new) begin
                r_count <= r_count + 1'b1;
            end
            if (r_state == ST_EMIT && slot_free) begin
                r_out_valid <= 1'b1;
            end else if (o_res_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (cmd_fire) begin
                    r_cmd    <= i_cmd_ch.command;
                    r_key    <= i_cmd_ch.stamp;
                    r_pose   <= pose_in;
                    r_idx    <= '0;
                    r_status <= STATUS_OK;
                    r_hit    <= 1'b0;
                    r_new    <= 1'b0;
                end
            end
            ST_SCAN_RD: begin
                // Ran off the end: position is the entry count.
                if (r_idx == r_count) r_found <= 1'b0;
            end
            ST_SCAN_CMP: begin
                if (cmp.lt) begin
                    r_prev <= rd_key;
                    r_idx  <= r_idx + 1'b1;
                end else begin
                    r_cur   <= rd_key;
                    r_eq    <= cmp.eq;
                    r_found <= 1'b1;
                end
            end
            ST_DECIDE: begin
                r_j <= r_count;
                if (r_cmd == CMD_INSERT) begin
                    if (!(r_found && r_eq)) begin
                        if (r_count == CNT_W'(TABLE_DEPTH)) begin
                            r_status <= STATUS_FULL;
                        end else begin
                            r_new <= 1'b1;
                        end
                    end
                end else begin
                    if (r_count == '0) begin
                        r_status <= STATUS_EMPTY;
                    end else if (r_idx == '0) begin
                        r_sel <= '0;
                    end else if (!r_found) begin
                        r_sel <= idx_m1[IDX_W-1:0];
                    end
                end
            end
            ST_SHIFT_WR: begin
                r_j <= jm1;
            end
            ST_DIST_LO: begin
                r_below <= cmp.diff;
            end
            ST_DIST_HI: begin
                r_above <= cmp.diff;
            end
            ST_PICK: begin
                // Tie goes to the earlier entry.
                r_sel <= cmp.lt ? r_idx[IDX_W-1:0] : idx_m1[IDX_W-1:0];
            end
            ST_FETCH_RD: begin
                r_hit <= 1'b1;
            end
            default: ;
        endcase
    end

    // Output register: load the result from RAM read data or zeros
    always_ff @(posedge i_clk) begin
        if (r_state == ST_EMIT && slot_free) begin
            r_out_status <= r_status;
            r_out_stamp  <= r_hit ? rd_key : '0;
            for (int p = 0; p < NUM_POSE; p++) begin
                r_out_pose[p] <= r_hit
                    ? FIELD_W'($unsigned(ram_rdata[p*POSE_BITS +: POSE_BITS])) : '0;
            end
        end
    end

    assign o_res_ch.valid        = r_out_valid;
    assign o_res_ch.status       = r_out_status;
    assign o_res_ch.chosen_stamp = r_out_stamp;
    assign o_res_ch.pos_x_out    = r_out_pose[0];
    assign o_res_ch.pos_y_out    = r_out_pose[1];
    assign o_res_ch.pos_z_out    = r_out_pose[2];
    assign o_res_ch.rot_x_out    = r_out_pose[3];
    assign o_res_ch.rot_y_out    = r_out_pose[4];
    assign o_res_ch.rot_z_out    = r_out_pose[5];
    assign o_res_ch.rot_w_out    = r_out_pose[6];

endmodule

### rtl/core/ntpl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ntpl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end
endmodule

### rtl/core/ntpl_alu.sv
// Shared 63-bit subtract/compare unit: difference, less-than and equality.
// Depends on ntpl_pkg.
module ntpl_alu import ntpl_pkg::*; (
    input  logic [STAMP_W-1:0] i_a,
    input  logic [STAMP_W-1:0] i_b,
    output t_cmp               o_cmp
);
    logic [STAMP_W:0] full_diff;

    // Borrow out of the extended subtraction is a < b.
    assign full_diff   = {1'b0, i_a} - {1'b0, i_b};
    assign o_cmp.diff  = full_diff[STAMP_W-1:0];
    assign o_cmp.lt    = full_diff[STAMP_W];
    assign o_cmp.eq    = (full_diff == '0);
endmodule
